/* hw/rtl/plb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and blend mode codes for the pixel layer blend block.
// ----------------------------------------------------------------------------
package plb_pkg;

   typedef logic [1:0] blend_mode_type;
   typedef logic [7:0] chan_type;

   localparam blend_mode_type MODE_MULTIPLY = 2'd0;
   localparam blend_mode_type MODE_SUBTRACT = 2'd1;
   localparam blend_mode_type MODE_OVERLAY  = 2'd2;
   localparam blend_mode_type MODE_SCREEN   = 2'd3;

   localparam chan_type CHAN_MAX = 8'd255;

endpackage
`default_nettype wire

/* hw/rtl/plb_blend_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plb_blend_core
// Combinational blend of two channel values: one 8x8 product, a divide by
// 255 through a reciprocal multiply with one correction step, and a final
// select per mode.
// ----------------------------------------------------------------------------
module plb_blend_core (
   input  plb_pkg::blend_mode_type mode,
   input  plb_pkg::chan_type       layer_a,
   input  plb_pkg::chan_type       layer_b,
   output plb_pkg::chan_type       blended
);
   import plb_pkg::*;

   logic        use_inv;
   logic        dbl;
   chan_type    op_a;
   chan_type    op_b;
   logic [15:0] prod;
   logic [16:0] num;
   logic [24:0] recip;
   logic [8:0]  q0;
   logic [16:0] q0_x255;
   logic [16:0] rem;
   logic [8:0]  quot;
   chan_type    diff;

   // Inverted operands take the ceiling form: ceil(x/255) = floor((x+254)/255)
   assign use_inv = (mode == MODE_SCREEN) || ((mode == MODE_OVERLAY) && layer_b[7]);
   assign dbl     = (mode == MODE_OVERLAY);
   assign op_a    = use_inv ? (CHAN_MAX - layer_a) : layer_a;
   assign op_b    = use_inv ? (CHAN_MAX - layer_b) : layer_b;
   assign prod    = op_a * op_b;
   assign num     = (dbl ? {prod, 1'b0} : {1'b0, prod}) + (use_inv ? 17'd254 : 17'd0);

   // x*257/65536 is floor(x/255) or one below it for x under 2^17
   assign recip   = {num, 8'd0} + {8'd0, num};
   assign q0      = recip[24:16];
   assign q0_x255 = {q0, 8'd0} - {8'd0, q0};
   assign rem     = num - q0_x255;
   assign quot    = (rem >= 17'd255) ? (q0 + 9'd1) : q0;

   assign diff    = (layer_a >= layer_b) ? (layer_a - layer_b) : 8'd0;

   always_comb begin
      unique case (mode)
         MODE_MULTIPLY: blended = quot[7:0];
         MODE_SUBTRACT: blended = diff;
         MODE_OVERLAY:  blended = use_inv ? (CHAN_MAX - quot[7:0]) : quot[7:0];
         MODE_SCREEN:   blended = CHAN_MAX - quot[7:0];
         default:       blended = quot[7:0];
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/pixel_layer_blend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_layer_blend
// Per-channel blend of two image layers selected by a mode register.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input passes the input register, then the result
//   register after the blend logic.
// Throughput: one item per cycle while rsp_ready is high; the single 8x8 multiply
//   and divide-by-255 path between the two registers sets the cycle time.
// Reset: synchronous; clears both valid flags and sets the mode to multiply.
module pixel_layer_blend (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  plb_pkg::chan_type       req_layer_a,
   input  plb_pkg::chan_type       req_layer_b,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output plb_pkg::chan_type       rsp_blended,
   input  wire                     csr_wr_en,
   input  plb_pkg::blend_mode_type csr_wr_data
);
   import plb_pkg::*;

   blend_mode_type mode_ff;
   logic           in_valid_ff;
   logic           in_valid_in;
   chan_type       a_ff;
   chan_type       b_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   chan_type       out_data_ff;
   chan_type       blend_res;
   logic           out_adv;
   logic           req_take;

   // Result register is free when empty or being drained this cycle
   assign out_adv   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_adv;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_adv);
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_MULTIPLY;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_ff <= req_layer_a;
         b_ff <= req_layer_b;
      end
      if (out_adv && in_valid_ff) begin
         out_data_ff <= blend_res;
      end
   end

   plb_blend_core u_core (
      .mode    (mode_ff),
      .layer_a (a_ff),
      .layer_b (b_ff),
      .blended (blend_res)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_blended = out_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!in_valid_ff || out_adv))
      else $error("input register overwritten while holding an item");

   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_adv) |=> rsp_valid)
      else $error("item lost between input and result register");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !out_valid_ff) |-> req_ready)
      else $error("block not ready while empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff))
      else $error("valid flags not cleared by reset");

endmodule
`default_nettype wire
